[design/assert_macros.svh]
// Assertion macros for the design files that include them.
// SYNTH selects the empty forms for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

[design/cmm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmm_pkg
// Types and constants of the complex matrix multiplier.
// ----------------------------------------------------------------------------
package cmm_pkg;

    localparam int IN_W       = 16;
    localparam int SUM_W      = 36;
    localparam int DIM_W      = 4;
    localparam int IDX_W      = 3;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int RESULT_CAP = 8;

    localparam logic [KIND_W-1:0] KIND_LOAD_A  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_B  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_A_COMPLEX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_B_COMPLEX = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [IDX_W-1:0]        row_index;
        logic [IDX_W-1:0]        col_index;
        logic signed [IN_W-1:0]  value_re;
        logic signed [IN_W-1:0]  value_im;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]        out_col;
        logic signed [SUM_W-1:0] out_re;
        logic signed [SUM_W-1:0] out_im;
        logic                    last;
        logic                    bad_row;
    } t_out_item;

    // tag that travels with each multiply-accumulate term
    typedef struct packed {
        logic             vld;
        logic             first;
        logic             last;
        logic             fin;
        logic [IDX_W-1:0] col;
    } t_mac_tag;

    // zero counts as one, values above the cap as the cap
    function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] r, input int cap);
        logic [DIM_W-1:0] d;
        d = r;
        if (r == '0) begin
            d = DIM_W'(1);
        end else if (int'(r) > cap) begin
            d = DIM_W'(cap);
        end
        return d;
    endfunction

endpackage

[design/cmm_cmac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmm_cmac
// Complex multiply-accumulate: registered products, then a 36-bit accumulator.
// ----------------------------------------------------------------------------
module cmm_cmac #(
    parameter int ELEM_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cmm_pkg::t_mac_tag               i_tag,
    input  logic signed [ELEM_BITS-1:0]     i_a_re,
    input  logic signed [ELEM_BITS-1:0]     i_a_im,
    input  logic signed [ELEM_BITS-1:0]     i_b_re,
    input  logic signed [ELEM_BITS-1:0]     i_b_im,
    output cmm_pkg::t_mac_tag               o_tag,
    output logic [cmm_pkg::SUM_W-1:0]       o_re,
    output logic [cmm_pkg::SUM_W-1:0]       o_im
);

    localparam int PW = 2 * ELEM_BITS;
    localparam int XW = (PW > cmm_pkg::SUM_W) ? PW : cmm_pkg::SUM_W;

    logic signed [PW-1:0] m_rr, m_ii, m_ri, m_ir;
    logic signed [PW-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir;
    logic signed [XW-1:0] x_rr, x_ii, x_ri, x_ir;
    logic [cmm_pkg::SUM_W-1:0] r_acc_re, r_acc_im;
    logic [cmm_pkg::SUM_W-1:0] n_acc_re, n_acc_im;
    logic [cmm_pkg::SUM_W-1:0] w_base_re, w_base_im;
    cmm_pkg::t_mac_tag r_tag1, r_tag2;

    assign m_rr = i_a_re * i_b_re;
    assign m_ii = i_a_im * i_b_im;
    assign m_ri = i_a_re * i_b_im;
    assign m_ir = i_a_im * i_b_re;

    assign x_rr = XW'(r_p_rr);
    assign x_ii = XW'(r_p_ii);
    assign x_ri = XW'(r_p_ri);
    assign x_ir = XW'(r_p_ir);

    assign w_base_re = r_tag1.first ? '0 : r_acc_re;
    assign w_base_im = r_tag1.first ? '0 : r_acc_im;
    assign n_acc_re  = w_base_re + x_rr[cmm_pkg::SUM_W-1:0] - x_ii[cmm_pkg::SUM_W-1:0];
    assign n_acc_im  = w_base_im + x_ri[cmm_pkg::SUM_W-1:0] + x_ir[cmm_pkg::SUM_W-1:0];

    always_ff @(posedge i_clk) begin
        r_p_rr <= m_rr;
        r_p_ii <= m_ii;
        r_p_ri <= m_ri;
        r_p_ir <= m_ir;
        if (r_tag1.vld) begin
            r_acc_re <= n_acc_re;
            r_acc_im <= n_acc_im;
        end
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
        end
    end

    assign o_tag = r_tag2;
    assign o_re  = r_acc_re;
    assign o_im  = r_acc_im;

endmodule

[design/complex_matrix_multiply.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_matrix_multiply
// One product row per compute item from element stores of A and B.
// ----------------------------------------------------------------------------
// Loads are written to the element stores; busy stays low.
// A compute item keeps busy high until its last column result is out; the
// shared complex MAC takes one term per cycle, the store reads pace it.
// Result of column c passes store read, products, accumulator, output register; never stalled.
// A bad row gives its single result the cycle after start, busy stays low.
// Sync active-low reset: config to 8/8/8/0/0, stores are not cleared.
`include "assert_macros.svh"

module complex_matrix_multiply #(
    parameter int MAX_DIM   = 8,
    parameter int ELEM_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  cmm_pkg::t_in_item                i_item,
    output logic                             o_valid,
    output cmm_pkg::t_out_item               o_result,
    input  logic                             i_cfg_we,
    input  logic [cmm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cmm_pkg::DIM_W-1:0]        i_cfg_data
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WW    = 2 * ELEM_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } t_state;

    t_state r_state, n_state;

    logic [cmm_pkg::DIM_W-1:0] r_rows_a, r_inner_dim, r_cols_b;
    logic                      r_a_cplx, r_b_cplx;
    logic [cmm_pkg::DIM_W-1:0] w_nr, w_nk, w_nc, w_nc_cap;

    logic [WW-1:0] mem_a [DEPTH];
    logic [WW-1:0] mem_b [DEPTH];
    logic [WW-1:0] r_rd_a, r_rd_b;

    logic                      w_accept, w_load_ok;
    logic [AW-1:0]             w_waddr, w_raddr_a, w_raddr_b;
    logic [ELEM_BITS-1:0]      w_wr_re, w_wr_im;

    logic [cmm_pkg::DIM_W-1:0] r_k, n_k;
    logic [cmm_pkg::IDX_W-1:0] r_c, n_c;
    logic [cmm_pkg::IDX_W-1:0] r_row, n_row;
    cmm_pkg::t_mac_tag         r_s1, n_s1, w_mac_tag;
    cmm_pkg::t_out_item        r_out, n_out;
    logic                      r_o_valid, n_o_valid;
    logic                      w_k_last;

    logic signed [ELEM_BITS-1:0] w_a_re, w_a_im, w_b_re, w_b_im;
    logic [cmm_pkg::SUM_W-1:0]   w_sum_re, w_sum_im;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= cmm_pkg::DIM_W'(8);
            r_inner_dim <= cmm_pkg::DIM_W'(8);
            r_cols_b    <= cmm_pkg::DIM_W'(8);
            r_a_cplx    <= 1'b0;
            r_b_cplx    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cmm_pkg::CFG_ROWS_A:    r_rows_a    <= i_cfg_data;
                cmm_pkg::CFG_INNER_DIM: r_inner_dim <= i_cfg_data;
                cmm_pkg::CFG_COLS_B:    r_cols_b    <= i_cfg_data;
                cmm_pkg::CFG_A_COMPLEX: r_a_cplx    <= i_cfg_data[0];
                cmm_pkg::CFG_B_COMPLEX: r_b_cplx    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_nr     = cmm_pkg::dim_clamp(r_rows_a, MAX_DIM);
    assign w_nk     = cmm_pkg::dim_clamp(r_inner_dim, MAX_DIM);
    assign w_nc     = cmm_pkg::dim_clamp(r_cols_b, MAX_DIM);
    assign w_nc_cap = (int'(w_nc) > cmm_pkg::RESULT_CAP)
                      ? cmm_pkg::DIM_W'(cmm_pkg::RESULT_CAP) : w_nc;

    // element stores
    assign w_accept  = start && !busy;
    assign w_load_ok = (int'(i_item.row_index) < MAX_DIM) && (int'(i_item.col_index) < MAX_DIM);
    assign w_waddr   = AW'(int'(i_item.row_index) * MAX_DIM + int'(i_item.col_index));
    assign w_wr_re   = ELEM_BITS'(32'(i_item.value_re));
    assign w_wr_im   = ELEM_BITS'(32'(i_item.value_im));
    assign w_raddr_a = AW'(int'(r_row) * MAX_DIM + int'(r_k));
    assign w_raddr_b = AW'(int'(r_k) * MAX_DIM + int'(r_c));

    always_ff @(posedge i_clk) begin
        if (w_accept && w_load_ok && i_item.kind == cmm_pkg::KIND_LOAD_A) begin
            mem_a[w_waddr] <= {w_wr_re, w_wr_im};
        end
        if (w_accept && w_load_ok && i_item.kind == cmm_pkg::KIND_LOAD_B) begin
            mem_b[w_waddr] <= {w_wr_re, w_wr_im};
        end
        r_rd_a <= mem_a[w_raddr_a];
        r_rd_b <= mem_b[w_raddr_b];
    end

    assign w_a_re = r_rd_a[WW-1:ELEM_BITS];
    assign w_a_im = r_a_cplx ? r_rd_a[ELEM_BITS-1:0] : '0;
    assign w_b_re = r_rd_b[WW-1:ELEM_BITS];
    assign w_b_im = r_b_cplx ? r_rd_b[ELEM_BITS-1:0] : '0;

    cmm_cmac #(
        .ELEM_BITS (ELEM_BITS)
    ) u_cmac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_s1),
        .i_a_re  (w_a_re),
        .i_a_im  (w_a_im),
        .i_b_re  (w_b_re),
        .i_b_im  (w_b_im),
        .o_tag   (w_mac_tag),
        .o_re    (w_sum_re),
        .o_im    (w_sum_im)
    );

    // sequencer
    assign w_k_last = (r_k == w_nk - cmm_pkg::DIM_W'(1));

    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_c       = r_c;
        n_row     = r_row;
        n_s1      = '0;
        n_o_valid = 1'b0;
        n_out     = r_out;
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_item.kind == cmm_pkg::KIND_COMPUTE) begin
                    n_row = i_item.row_index;
                    n_k   = '0;
                    n_c   = '0;
                    if ({1'b0, i_item.row_index} >= w_nr) begin
                        n_o_valid     = 1'b1;
                        n_out.out_col = '0;
                        n_out.out_re  = '0;
                        n_out.out_im  = '0;
                        n_out.last    = 1'b1;
                        n_out.bad_row = 1'b1;
                    end else begin
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                n_s1.vld   = 1'b1;
                n_s1.first = (r_k == '0);
                n_s1.last  = w_k_last;
                n_s1.col   = r_c;
                n_s1.fin   = w_k_last && ({1'b0, r_c} == w_nc_cap - cmm_pkg::DIM_W'(1));
                if (w_k_last) begin
                    n_k = '0;
                    n_c = r_c + cmm_pkg::IDX_W'(1);
                    if (n_s1.fin) begin
                        n_state = S_DRAIN;
                    end
                end else begin
                    n_k = r_k + cmm_pkg::DIM_W'(1);
                end
            end
            S_DRAIN: ;
            default: n_state = S_IDLE;
        endcase
        if (w_mac_tag.vld && w_mac_tag.last) begin
            n_o_valid     = 1'b1;
            n_out.out_col = w_mac_tag.col;
            n_out.out_re  = $signed(w_sum_re);
            n_out.out_im  = $signed(w_sum_im);
            n_out.last    = w_mac_tag.fin;
            n_out.bad_row = 1'b0;
            if (w_mac_tag.fin) begin
                n_state = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_k   <= n_k;
        r_c   <= n_c;
        r_row <= n_row;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_s1      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_s1      <= n_s1;
            r_o_valid <= n_o_valid;
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_o_valid;
    assign o_result = r_out;

    `ASSERT_NEVER(a_bad_row_last, i_clk, i_rst_n, o_valid && o_result.bad_row && !o_result.last)
    `ASSERT_PROP(a_compute_acts, i_clk, i_rst_n, start && !busy && i_item.kind == cmm_pkg::KIND_COMPUTE |=> busy || o_valid)
    `ASSERT_NEVER(a_idle_no_terms, i_clk, i_rst_n, !busy && r_s1.vld)
    `ASSERT_PROP(a_row_result_busy, i_clk, i_rst_n, o_valid && !o_result.bad_row |-> $past(busy))

endmodule
